[hdl/periodic_box_wrap_and_min_image_macros.svh]
// ----------------------------------------------------------------------------
// Periodic box assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_BOX_WRAP_AND_MIN_IMAGE_MACROS_SVH
`define PERIODIC_BOX_WRAP_AND_MIN_IMAGE_MACROS_SVH

`ifndef SYNTH
`define PBW_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define PBW_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PBW_ASSERT_IMPL(name, clk, rst, ante, cons)
`define PBW_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

[hdl/pbw_pkg.sv]
// ----------------------------------------------------------------------------
// Periodic box package
// Widths, register indexes, function codes and pipeline control types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pbw_pkg;

   localparam int COORD_BITS  = 32;
   localparam int FRAC_BITS   = 16;
   localparam int PROD_SHIFT  = FRAC_BITS + 32;
   localparam int LEN_BITS    = 31;
   localparam int INV_BITS    = 33;
   localparam int SEP_BITS    = 31;
   localparam int DIFF_BITS   = COORD_BITS + 1;
   localparam int PROD_BITS   = 2 * DIFF_BITS;
   localparam int QUOT_BITS   = 18;
   localparam int KL_BITS     = QUOT_BITS + LEN_BITS + 1;
   localparam int RES_BITS    = KL_BITS + 2;
   localparam int SQ_BITS     = 2 * COORD_BITS;
   localparam int ROOT_BITS   = COORD_BITS;

   localparam int AXIS_STAGES = 6;
   localparam int SQRT_STAGES = 8;
   localparam int SQRT_STEPS  = 4;
   localparam int PIPE_STAGES = AXIS_STAGES + 2 + SQRT_STAGES;

   localparam logic [INV_BITS-1:0] INV_ONE   = INV_BITS'(64'd1 << 32);
   localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(64'd1 << FRAC_BITS);

   localparam logic FUNC_WRAP      = 1'b0;
   localparam logic FUNC_MIN_IMAGE = 1'b1;

   typedef enum logic {
      CSR_BOX_LENGTH     = 1'b0,
      CSR_INV_BOX_LENGTH = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [AXIS_STAGES-1:0] load;
   } axis_ctrl_type;

   typedef struct packed {
      logic [SQRT_STAGES-1:0] load;
   } sqrt_ctrl_type;

endpackage

`default_nettype wire

[hdl/periodic_box_wrap_and_min_image.sv]
// Throughput: one request per cycle while the response side is not stalling; the 33x33
// reciprocal multiply per axis and the eight-stage square root pipeline each take one request per cycle.
// Stalls propagate stage by stage, so empty stages keep filling.
// Reset: synchronous; clears all stage valid bits, box_length to 1.0 and
// inv_box_length to 1.0.
// ----------------------------------------------------------------------------
// Periodic box wrap and minimum-image unit
// Wraps a point into the box or gives the minimum-image displacement and distance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "periodic_box_wrap_and_min_image_macros.svh"

module periodic_box_wrap_and_min_image (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  pbw_pkg::csr_index_type                 csr_index,
   input  logic [pbw_pkg::INV_BITS-1:0]           csr_wdata,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_func,
   input  logic signed [pbw_pkg::COORD_BITS-1:0]  req_a_x,
   input  logic signed [pbw_pkg::COORD_BITS-1:0]  req_a_y,
   input  logic signed [pbw_pkg::COORD_BITS-1:0]  req_a_z,
   input  logic signed [pbw_pkg::COORD_BITS-1:0]  req_b_x,
   input  logic signed [pbw_pkg::COORD_BITS-1:0]  req_b_y,
   input  logic signed [pbw_pkg::COORD_BITS-1:0]  req_b_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [pbw_pkg::COORD_BITS-1:0]  rsp_out_x,
   output logic signed [pbw_pkg::COORD_BITS-1:0]  rsp_out_y,
   output logic signed [pbw_pkg::COORD_BITS-1:0]  rsp_out_z,
   output logic        [pbw_pkg::SEP_BITS-1:0]    rsp_separation
);
   import pbw_pkg::*;

   localparam int SQ_STAGE  = AXIS_STAGES;
   localparam int SUM_STAGE = AXIS_STAGES + 1;
   localparam int LAST      = PIPE_STAGES - 1;

   logic [LEN_BITS-1:0]     box_length_ff;
   logic [INV_BITS-1:0]     inv_box_length_ff, inv_eff;
   logic [PIPE_STAGES-1:0]  valid_ff, load;
   logic                    func_ff [PIPE_STAGES];
   logic signed [COORD_BITS-1:0] a_in [3];
   logic signed [COORD_BITS-1:0] b_in [3];
   logic signed [COORD_BITS-1:0] axis_res [3];
   logic signed [COORD_BITS-1:0] crd_ff [SQ_STAGE:LAST][3];
   logic [COORD_BITS-1:0]   mag [3];
   logic [SQ_BITS-1:0]      sq_ff [3];
   logic [SQ_BITS-1:0]      sq_in [3];
   logic [SQ_BITS-1:0]      sum_ff, sum_in;
   logic [ROOT_BITS-1:0]    root;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         box_length_ff     <= LEN_RESET;
         inv_box_length_ff <= INV_ONE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BOX_LENGTH:     box_length_ff     <= csr_wdata[LEN_BITS-1:0];
            CSR_INV_BOX_LENGTH: inv_box_length_ff <= csr_wdata;
            default:            ;
         endcase
      end
   end

   assign inv_eff = (inv_box_length_ff > INV_ONE) ? INV_ONE : inv_box_length_ff;

   // stage advance: a stage loads when empty or when its successor loads
   always_comb begin
      load[LAST] = !valid_ff[LAST] || rsp_ready;
      for (int i = LAST - 1; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
   end

   assign req_ready = load[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < PIPE_STAGES; i++) begin
            if (load[i]) valid_ff[i] <= (i == 0) ? req_valid : valid_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < PIPE_STAGES; i++) begin
         if (load[i]) func_ff[i] <= (i == 0) ? req_func : func_ff[(i == 0) ? 0 : i - 1];
      end
   end

   assign a_in[0] = req_a_x;
   assign a_in[1] = req_a_y;
   assign a_in[2] = req_a_z;
   assign b_in[0] = req_b_x;
   assign b_in[1] = req_b_y;
   assign b_in[2] = req_b_z;

   for (genvar g = 0; g < 3; g++) begin : g_axis
      pbw_axis u_axis (
         .clock          (clock),
         .ctrl           (axis_ctrl_type'(load[AXIS_STAGES-1:0])),
         .func           (req_func),
         .a              (a_in[g]),
         .b              (b_in[g]),
         .box_length     (box_length_ff),
         .inv_box_length (inv_eff),
         .result         (axis_res[g])
      );
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mag[k]   = axis_res[k][COORD_BITS-1] ? COORD_BITS'(-axis_res[k])
                                              : COORD_BITS'(axis_res[k]);
         sq_in[k] = SQ_BITS'(mag[k]) * SQ_BITS'(mag[k]);
      end
      sum_in = (func_ff[SQ_STAGE] == FUNC_MIN_IMAGE) ? (sq_ff[0] + sq_ff[1] + sq_ff[2]) : '0;
   end

   // squares, then sum; coordinates travel alongside
   always_ff @(posedge clock) begin
      if (load[SQ_STAGE]) begin
         for (int k = 0; k < 3; k++) begin
            sq_ff[k]            <= sq_in[k];
            crd_ff[SQ_STAGE][k] <= axis_res[k];
         end
      end
      if (load[SUM_STAGE]) begin
         sum_ff <= sum_in;
      end
      for (int i = SQ_STAGE + 1; i <= LAST; i++) begin
         if (load[i]) begin
            for (int k = 0; k < 3; k++) begin
               crd_ff[i][k] <= crd_ff[(i > SQ_STAGE) ? i - 1 : SQ_STAGE][k];
            end
         end
      end
   end

   pbw_isqrt u_isqrt (
      .clock    (clock),
      .ctrl     (sqrt_ctrl_type'(load[LAST:SUM_STAGE+1])),
      .radicand (sum_ff),
      .root     (root)
   );

   assign rsp_valid      = valid_ff[LAST];
   assign rsp_out_x      = crd_ff[LAST][0];
   assign rsp_out_y      = crd_ff[LAST][1];
   assign rsp_out_z      = crd_ff[LAST][2];
   assign rsp_separation = root[ROOT_BITS-1] ? {SEP_BITS{1'b1}} : root[SEP_BITS-1:0];

   `PBW_ASSERT_IMPL(a_wrap_sep_zero, clock, reset, rsp_valid && (func_ff[LAST] == FUNC_WRAP), rsp_separation == '0)
   `PBW_ASSERT_IMPL(a_empty_tail_ready, clock, reset, !valid_ff[LAST], req_ready)
   `PBW_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && req_ready, valid_ff[0])

endmodule

`default_nettype wire

[hdl/pbw_axis.sv]
// ----------------------------------------------------------------------------
// Periodic box axis pipeline
// Six-stage wrap or minimum-image reduction of one coordinate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbw_axis (
   input  logic                                     clock,
   input  pbw_pkg::axis_ctrl_type                   ctrl,
   input  logic                                     func,
   input  logic signed [pbw_pkg::COORD_BITS-1:0]    a,
   input  logic signed [pbw_pkg::COORD_BITS-1:0]    b,
   input  logic        [pbw_pkg::LEN_BITS-1:0]      box_length,
   input  logic        [pbw_pkg::INV_BITS-1:0]      inv_box_length,
   output logic signed [pbw_pkg::COORD_BITS-1:0]    result
);
   import pbw_pkg::*;

   localparam logic [PROD_BITS:0] BIAS_CEIL = (PROD_BITS'(1) << PROD_SHIFT) - 1'b1;
   localparam logic [PROD_BITS:0] BIAS_HALF = PROD_BITS'(1) << (PROD_SHIFT - 1);
   localparam logic signed [RES_BITS-1:0] SAT_HI =
      RES_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
   localparam logic signed [RES_BITS-1:0] SAT_LO = -SAT_HI - RES_BITS'(1);

   logic                        func1_ff, func2_ff, func3_ff, func4_ff, func5_ff;
   logic signed [DIFF_BITS-1:0] diff1_ff, diff2_ff, diff3_ff, diff4_ff;
   logic signed [DIFF_BITS-1:0] diff1_in;
   logic                        neg2_ff;
   logic [PROD_BITS-1:0]        prod2_ff, prod2_in;
   logic [DIFF_BITS-1:0]        mag;
   logic [PROD_BITS:0]          bias, biased;
   logic [QUOT_BITS-2:0]        quot;
   logic signed [QUOT_BITS-1:0] quot3_ff, quot3_in;
   logic signed [KL_BITS-1:0]   kl4_ff, kl4_in;
   logic signed [RES_BITS-1:0]  res5_ff, res5_in, res_raw, res6, len, half, neg_half;
   logic signed [COORD_BITS-1:0] result_ff, result_in;

   always_comb begin
      len      = RES_BITS'($signed({1'b0, box_length}));
      half     = len >>> 1;
      neg_half = -((len + RES_BITS'(1)) >>> 1);

      if (func == FUNC_MIN_IMAGE) begin
         diff1_in = DIFF_BITS'(a) - DIFF_BITS'(b);
      end else begin
         diff1_in = DIFF_BITS'(a);
      end

      mag      = diff1_ff[DIFF_BITS-1] ? DIFF_BITS'(-diff1_ff) : DIFF_BITS'(diff1_ff);
      prod2_in = PROD_BITS'(mag) * PROD_BITS'(inv_box_length);

      if (func2_ff == FUNC_MIN_IMAGE) begin
         bias = BIAS_HALF;
      end else if (neg2_ff) begin
         bias = BIAS_CEIL;
      end else begin
         bias = '0;
      end
      biased   = {1'b0, prod2_ff} + bias;
      quot     = biased[PROD_SHIFT +: QUOT_BITS-1];
      quot3_in = neg2_ff ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

      kl4_in = KL_BITS'(quot3_ff) * KL_BITS'($signed({1'b0, box_length}));

      res_raw = RES_BITS'(diff4_ff) - RES_BITS'(kl4_ff);
      res5_in = res_raw;
      if (func4_ff == FUNC_MIN_IMAGE) begin
         if (res_raw > half) res5_in = res_raw - len;
      end else begin
         if (res_raw >= len) res5_in = res_raw - len;
      end

      res6 = res5_ff;
      if (func5_ff == FUNC_MIN_IMAGE) begin
         if (res5_ff <= neg_half) res6 = res5_ff + len;
      end else begin
         if (res5_ff < 0) res6 = res5_ff + len;
      end
      priority if (res6 > SAT_HI) begin
         result_in = COORD_BITS'(SAT_HI);
      end else if (res6 < SAT_LO) begin
         result_in = COORD_BITS'(SAT_LO);
      end else begin
         result_in = COORD_BITS'(res6);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         func1_ff <= func;
         diff1_ff <= diff1_in;
      end
      if (ctrl.load[1]) begin
         func2_ff <= func1_ff;
         diff2_ff <= diff1_ff;
         neg2_ff  <= diff1_ff[DIFF_BITS-1];
         prod2_ff <= prod2_in;
      end
      if (ctrl.load[2]) begin
         func3_ff <= func2_ff;
         diff3_ff <= diff2_ff;
         quot3_ff <= quot3_in;
      end
      if (ctrl.load[3]) begin
         func4_ff <= func3_ff;
         diff4_ff <= diff3_ff;
         kl4_ff   <= kl4_in;
      end
      if (ctrl.load[4]) begin
         func5_ff <= func4_ff;
         res5_ff  <= res5_in;
      end
      if (ctrl.load[5]) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

[hdl/pbw_isqrt.sv]
// ----------------------------------------------------------------------------
// Periodic box square root pipeline
// Floor square root of a 64-bit value, four result bits per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbw_isqrt (
   input  logic                              clock,
   input  pbw_pkg::sqrt_ctrl_type            ctrl,
   input  logic [pbw_pkg::SQ_BITS-1:0]       radicand,
   output logic [pbw_pkg::ROOT_BITS-1:0]     root
);
   import pbw_pkg::*;

   logic [SQ_BITS-1:0] rem_ff [SQRT_STAGES];
   logic [SQ_BITS-1:0] acc_ff [SQRT_STAGES];
   logic [SQ_BITS-1:0] rem_in [SQRT_STAGES];
   logic [SQ_BITS-1:0] acc_in [SQRT_STAGES];

   always_comb begin
      logic [SQ_BITS-1:0] rem, acc, one_bit, trial;
      for (int s = 0; s < SQRT_STAGES; s++) begin
         rem = (s == 0) ? radicand : rem_ff[(s == 0) ? 0 : s - 1];
         acc = (s == 0) ? '0 : acc_ff[(s == 0) ? 0 : s - 1];
         for (int t = 0; t < SQRT_STEPS; t++) begin
            one_bit = SQ_BITS'(1) << (2 * (ROOT_BITS - 1 - s * SQRT_STEPS - t));
            trial   = acc + one_bit;
            if (rem >= trial) begin
               rem = rem - trial;
               acc = (acc >> 1) + one_bit;
            end else begin
               acc = acc >> 1;
            end
         end
         rem_in[s] = rem;
         acc_in[s] = acc;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < SQRT_STAGES; s++) begin
         if (ctrl.load[s]) begin
            rem_ff[s] <= rem_in[s];
            acc_ff[s] <= acc_in[s];
         end
      end
   end

   assign root = acc_ff[SQRT_STAGES-1][ROOT_BITS-1:0];

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Periodic box wrap and minimum-image testbench
// Drives wrap and minimum-image requests through the valid/ready channels,
// predicts each response from the box registers, and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
   import pbw_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   csr_index_type csr_index = CSR_BOX_LENGTH;
   logic [INV_BITS-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_func = FUNC_WRAP;
   logic signed [COORD_BITS-1:0] req_a_x = '0, req_a_y = '0, req_a_z = '0;
   logic signed [COORD_BITS-1:0] req_b_x = '0, req_b_y = '0, req_b_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [COORD_BITS-1:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic [SEP_BITS-1:0] rsp_separation;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] z;
      logic [SEP_BITS-1:0] sep;
   } image_result_type;

   image_result_type expected_images[$];
   logic [LEN_BITS-1:0] model_len;
   logic [INV_BITS-1:0] model_inv;
   bit failed = 1'b0;
   bit stim_done = 1'b0;
   int unsigned cycles = 0;

   periodic_box_wrap_and_min_image dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic signed [63:0] clamp_coord(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic [63:0] scale_by_inv(logic [63:0] mag, logic [127:0] bias);
      logic [127:0] p;
      logic [63:0] inv;
      inv = (model_inv > INV_ONE) ? 64'(INV_ONE) : 64'(model_inv);
      p = 128'(mag) * 128'(inv) + bias;
      return p[PROD_SHIFT +: 64];
   endfunction

   function automatic logic signed [63:0] fold_coord(logic signed [63:0] x);
      logic [63:0] mag, k;
      logic signed [63:0] r, l;
      mag = x < 0 ? -x : x;
      k = x < 0 ? -scale_by_inv(mag, (128'd1 << PROD_SHIFT) - 1) : scale_by_inv(mag, 0);
      l = 64'(model_len);
      r = x - k * 64'(model_len);
      if (r >= l) r -= l;
      if (r < 0) r += l;
      return clamp_coord(r);
   endfunction

   function automatic logic signed [63:0] nearest_image(logic signed [63:0] d);
      logic [63:0] mag, n;
      logic signed [63:0] r, l;
      mag = d < 0 ? -d : d;
      n = scale_by_inv(mag, 128'd1 << (PROD_SHIFT - 1));
      if (d < 0) n = -n;
      l = 64'(model_len);
      r = d - n * 64'(model_len);
      if (r > (l >>> 1)) r -= l;
      if (r <= -((l + 1) >>> 1)) r += l;
      return clamp_coord(r);
   endfunction

   function automatic logic [63:0] floor_sqrt(logic [63:0] n);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic image_result_type predict_image(logic f,
         logic signed [COORD_BITS-1:0] ax, ay, az, bx, by, bz);
      image_result_type res;
      logic signed [63:0] r[3];
      logic signed [63:0] av[3], bv[3];
      logic [127:0] sum;
      logic [63:0] m, s;
      av = '{ax, ay, az};
      bv = '{bx, by, bz};
      sum = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         if (f == FUNC_WRAP) begin
            r[i] = fold_coord(av[i]);
         end else begin
            r[i] = nearest_image(av[i] - bv[i]);
            m = r[i] < 0 ? -r[i] : r[i];
            sum += 128'(m) * 128'(m);
         end
      end
      if (f == FUNC_MIN_IMAGE) begin
         s = floor_sqrt(sum > 128'(64'hFFFF_FFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF_FFFF
                        : sum[63:0]);
         if (s > 64'h7FFF_FFFF) s = 64'h7FFF_FFFF;
      end
      res.x = r[0][31:0];
      res.y = r[1][31:0];
      res.z = r[2][31:0];
      res.sep = s[30:0];
      return res;
   endfunction

   task automatic wait_cycles(int n);
      repeat (n) @(posedge clock);
   endtask

   task automatic send_request(logic f, logic signed [COORD_BITS-1:0] ax, ay, az,
         bx, by, bz, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         wait_cycles(gap);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_a_x <= ax; req_a_y <= ay; req_a_z <= az;
      req_b_x <= bx; req_b_y <= by; req_b_z <= bz;
      expected_images.push_back(predict_image(f, ax, ay, az, bx, by, bz));
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_box(csr_index_type idx, logic [INV_BITS-1:0] value);
      req_valid <= 1'b0;
      wait (expected_images.size() == 0);
      wait_cycles(PIPE_STAGES + 4);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_BOX_LENGTH) model_len = value[LEN_BITS-1:0];
      else model_inv = value;
   endtask

   task automatic set_box(logic [LEN_BITS-1:0] len, logic [INV_BITS-1:0] inv);
      write_box(CSR_BOX_LENGTH, INV_BITS'(len));
      write_box(CSR_INV_BOX_LENGTH, inv);
   endtask

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
         2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 3)
                                        : 32'sh8000_0000 + $urandom_range(0, 3);
         default: return $signed($urandom_range(0, 1 << 26)) - (1 << 25);
      endcase
   endfunction

   task automatic test_directed_wrap();
      send_request(FUNC_WRAP, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0);
      send_request(FUNC_WRAP, 32'sh0001_0000, -32'sh0001_0000, 32'sh0000_8000,
                   32'shFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_request(FUNC_WRAP, -1, 1, 32'sh0002_8000, 0, 0, 0);
   endtask

   task automatic test_directed_min_image();
      send_request(FUNC_MIN_IMAGE, 32'sh7FFF_FFFF, 32'sh8000_0000, 0,
                   32'sh8000_0000, 32'sh7FFF_FFFF, 0);
      send_request(FUNC_MIN_IMAGE, 32'sh0000_8000, -32'sh0000_8000, 32'sh0001_8000,
                   0, 0, 0);
      send_request(FUNC_MIN_IMAGE, -1, 32'shFFFF_FFFF, 32'sh5555_5555,
                   0, 1, 32'shAAAA_AAAA);
   endtask

   task automatic test_random(int count);
      repeat (count) begin
         send_request(1'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 3) == 0);
      end
   endtask

   task automatic test_box_settings();
      set_box(31'h0003_0000, 33'h0_5555_5555);
      test_directed_wrap();
      test_directed_min_image();
      test_random(80);
      set_box(31'h7FFF_FFFF, 33'h0_0000_0002);
      test_directed_wrap();
      test_directed_min_image();
      test_random(60);
      set_box(31'h0001_0000, 33'h1_FFFF_FFFF);
      test_random(40);
      set_box(31'h0000_0000, 33'h0_0000_0000);
      test_directed_min_image();
      test_random(30);
      set_box(31'h0010_0000, 33'h0_3000_0000);
      test_random(40);
      set_box(31'h0000_A000, 33'h1_0000_0000);
      test_random(40);
      set_box(31'h0040_0000, 33'h0_0400_0000);
      test_random(80);
   endtask

   initial begin
      model_len = LEN_RESET;
      model_inv = INV_ONE;
      wait_cycles(9);
      reset <= 1'b0;
      wait_cycles(2);
      test_directed_wrap();
      test_directed_min_image();
      test_random(40);
      test_box_settings();
      req_valid <= 1'b0;
      wait (expected_images.size() == 0);
      wait_cycles(PIPE_STAGES + 10);
      stim_done = 1'b1;
   end

   always @(posedge clock) begin
      image_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_images.size() == 0) begin
            $display("%0t unexpected response x=%h", $time, rsp_out_x);
            failed = 1'b1;
         end else begin
            want = expected_images.pop_front();
            if (rsp_out_x !== want.x) begin
               $display("%0t out_x expected %h actual %h", $time, want.x, rsp_out_x);
               failed = 1'b1;
            end
            if (rsp_out_y !== want.y) begin
               $display("%0t out_y expected %h actual %h", $time, want.y, rsp_out_y);
               failed = 1'b1;
            end
            if (rsp_out_z !== want.z) begin
               $display("%0t out_z expected %h actual %h", $time, want.z, rsp_out_z);
               failed = 1'b1;
            end
            if (rsp_separation !== want.sep) begin
               $display("%0t separation expected %h actual %h", $time, want.sep,
                        rsp_separation);
               failed = 1'b1;
            end
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            wait_cycles($urandom_range(1, 19));
         end
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (stim_done) begin
            if (!failed && expected_images.size() == 0) $display("CHECK OK");
            else $display("CHECK FAILED");
            $finish;
         end else if (cycles > 200000) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

endmodule

`default_nettype wire

[periodic_box_wrap_and_min_image.f]
+incdir+hdl
hdl/pbw_pkg.sv
hdl/pbw_axis.sv
hdl/pbw_isqrt.sv
hdl/periodic_box_wrap_and_min_image.sv
tb/testbench.sv
